// File: rtl/core/dam_pkg.sv
// dam_pkg: widths, operation and status codes, opcodes and shared types
// for the decimal accumulator machine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dam_pkg;

  localparam int unsigned MEM_WORDS_DEF = 100;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned OPC_W  = 9;

  // host operations
  localparam logic [OP_W-1:0] HOP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] HOP_READ    = 2'd1;
  localparam logic [OP_W-1:0] HOP_EXEC    = 2'd2;
  localparam logic [OP_W-1:0] HOP_RESTART = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_HALT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_PAST    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd5;

  // instruction opcodes
  localparam logic [OPC_W-1:0] OPC_READ  = 9'd10;
  localparam logic [OPC_W-1:0] OPC_WRITE = 9'd11;
  localparam logic [OPC_W-1:0] OPC_LOAD  = 9'd20;
  localparam logic [OPC_W-1:0] OPC_STORE = 9'd21;
  localparam logic [OPC_W-1:0] OPC_ADD   = 9'd30;
  localparam logic [OPC_W-1:0] OPC_SUB   = 9'd31;
  localparam logic [OPC_W-1:0] OPC_DIV   = 9'd32;
  localparam logic [OPC_W-1:0] OPC_MUL   = 9'd33;
  localparam logic [OPC_W-1:0] OPC_BR    = 9'd40;
  localparam logic [OPC_W-1:0] OPC_BRNEG = 9'd41;
  localparam logic [OPC_W-1:0] OPC_BRZERO = 9'd42;
  localparam logic [OPC_W-1:0] OPC_HALT  = 9'd43;
  localparam logic [OPC_W-1:0] OPC_SHR   = 9'd50;

  // word / 100 as (word * 5243) >> 19, exact for 15-bit positive words
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;
  localparam logic [15:0] DEC_BASE  = 16'd100;

  // magnitude / 1000 as (magnitude * 33555) >> 25, exact up to 32768
  localparam logic [WORD_W-1:0] RECIP_1000    = 16'd33555;
  localparam int unsigned       RECIP_1000_SH = 25;
  localparam logic [WORD_W-1:0] SHR_MOD       = 16'd1000;
  localparam int unsigned       SHR_QUO_W     = 6;
  localparam int unsigned       SHR_REM_W     = 10;

  localparam int unsigned ALU_STEPS = 17;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

endpackage

`default_nettype wire

// File: rtl/core/dam_if.sv
// dam_in_if / dam_out_if: valid-ready channels of the accumulator machine
// depends on dam_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dam_in_if;
  import dam_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ADDR_W-1:0]        address;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, op, address, value, input ready);
  modport sink   (input valid, op, address, value, output ready);
endinterface

interface dam_out_if;
  import dam_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     out_valid;
  logic [ADDR_W-1:0]        out_address;
  logic signed [WORD_W-1:0] data;
  logic signed [WORD_W-1:0] acc_now;
  logic [ADDR_W-1:0]        pc_now;

  modport source (output valid, status, out_valid, out_address, data, acc_now, pc_now,
                  input ready);
  modport sink   (input valid, status, out_valid, out_address, data, acc_now, pc_now,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/dam_alu.sv
// dam_alu: shared iterative multiply / signed divide unit, one bit per cycle
// depends on dam_pkg
`timescale 1ns / 1ps
`default_nettype none

module dam_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dam_pkg::alu_req_t                 req_i,
  input  logic signed [dam_pkg::WORD_W-1:0] a_i,
  input  logic signed [dam_pkg::WORD_W-1:0] b_i,
  output logic                              done_o,
  output logic signed [dam_pkg::WORD_W-1:0] quo_o,
  output logic signed [dam_pkg::WORD_W-1:0] prod_o
);
  import dam_pkg::*;

  localparam int unsigned CNT_W = $clog2(ALU_STEPS);
  localparam int unsigned MAG_W = WORD_W + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             div_q, div_d;
  logic             negq_q, negq_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] r_q, r_d;
  logic [MAG_W-1:0] q_q, q_d;
  logic [MAG_W-1:0] d_q, d_d;

  logic [MAG_W-1:0] shl;
  logic [MAG_W-1:0] add_a, add_b;
  logic [MAG_W:0]   sum;
  logic [MAG_W-1:0] a_ext, b_ext, a_mag, b_mag;
  logic [MAG_W-1:0] quo_s;

  assign a_ext = {a_i[WORD_W-1], a_i};
  assign b_ext = {b_i[WORD_W-1], b_i};
  assign a_mag = a_i[WORD_W-1] ? (~a_ext + MAG_W'(1)) : a_ext;
  assign b_mag = b_i[WORD_W-1] ? (~b_ext + MAG_W'(1)) : b_ext;

  // one adder serves both the restoring divide and the shift-add multiply
  assign shl   = {r_q[MAG_W-2:0], q_q[MAG_W-1]};
  assign add_a = div_q ? shl : r_q;
  assign add_b = div_q ? ~d_q : d_q;
  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{MAG_W{1'b0}}, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    div_d  = div_q;
    negq_d = negq_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    q_d    = q_q;
    d_d    = d_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      div_d  = req_i.div;
      cnt_d  = '0;
      r_d    = '0;
      negq_d = a_i[WORD_W-1] ^ b_i[WORD_W-1];
      if (req_i.div) begin
        q_d = a_mag;
        d_d = b_mag;
      end else begin
        q_d = {1'b0, b_i};
        d_d = {1'b0, a_i};
      end
    end else if (busy_q) begin
      if (div_q) begin
        r_d = sum[MAG_W] ? sum[MAG_W-1:0] : shl;
        q_d = {q_q[MAG_W-2:0], sum[MAG_W]};
      end else begin
        r_d = q_q[0] ? sum[MAG_W-1:0] : r_q;
        q_d = q_q >> 1;
        d_d = d_q << 1;
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ALU_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    negq_q <= negq_d;
    r_q    <= r_d;
    q_q    <= q_d;
    d_q    <= d_d;
  end

  assign quo_s  = negq_q ? (~q_q + MAG_W'(1)) : q_q;
  assign done_o = done_q;
  assign quo_o  = quo_s[WORD_W-1:0];
  assign prod_o = r_q[WORD_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/decimal_accumulator_machine.sv
// decimal_accumulator_machine: accumulator machine with word memory, host access and
// single-instruction execution; depends on dam_pkg, dam_if, dam_alu
// order: dispatch, then for a host read a memory read, for an execute fetch, decode, operand
// read, execute (with shr steps or the shared bit-serial ALU) and finish; then the response
// throughput: one item at a time; the next item is taken once the result is registered
// reset: acc, pc and halt flag cleared, memory words read as zero through per-word valid bits
`timescale 1ns / 1ps
`default_nettype none

module decimal_accumulator_machine #(
  parameter int unsigned MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dam_in_if.sink     in_i,
  dam_out_if.source  out_o
);
  import dam_pkg::*;

  localparam int unsigned IDX_W = $clog2(MEM_WORDS);
  localparam logic [ADDR_W-1:0] MEM_LIM = ADDR_W'(MEM_WORDS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_HRD   = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_OPR   = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_ALU   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;
  localparam logic [3:0] S_SHRQ  = 4'd10;
  localparam logic [3:0] S_SHRR  = 4'd11;
  localparam logic [3:0] S_SHRX  = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [ADDR_W-1:0] haddr_q, haddr_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic              stop_q, stop_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [OPC_W-1:0]  opc_q, opc_d;
  logic [ADDR_W-1:0] opa_q, opa_d;
  logic [ADDR_W-1:0] next_q, next_d;
  logic              halt_q, halt_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic              ov_q, ov_d;
  logic [ADDR_W-1:0] oa_q, oa_d;
  logic [WORD_W-1:0] dat_q, dat_d;

  logic                 shr_neg_q, shr_neg_d;
  logic [WORD_W-1:0]    shr_mag_q, shr_mag_d;
  logic [SHR_QUO_W-1:0] shr_quo_q, shr_quo_d;
  logic [SHR_REM_W-1:0] shr_rem_q, shr_rem_d;

  logic              ovld_q, ovld_d;
  logic [STAT_W-1:0] o_st_q, o_st_d;
  logic              o_ov_q, o_ov_d;
  logic [ADDR_W-1:0] o_oa_q, o_oa_d;
  logic [WORD_W-1:0] o_dat_q, o_dat_d;
  logic [WORD_W-1:0] o_acc_q, o_acc_d;
  logic [ADDR_W-1:0] o_pc_q, o_pc_d;

  // word memory with per-word valid bits
  logic [WORD_W-1:0]    mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]    rd_word_q;
  logic                 rd_vld_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [WORD_W-1:0]    mem_wd;
  logic [WORD_W-1:0]    rd_val;

  alu_req_t                 alu_req;
  logic signed [WORD_W-1:0] alu_a, alu_b;
  logic                     alu_done;
  logic signed [WORD_W-1:0] alu_quo, alu_prod;

  logic [27:0]       recip_prod;
  logic [WORD_W-1:0] opc_x100, opa_full;
  logic              opa_ok;
  logic [WORD_W-1:0] m_val;
  logic [31:0]       shr_prod;
  logic [WORD_W-1:0] shr_diff;
  logic [WORD_W-1:0] shr_x10;

  assign rd_val     = rd_vld_q ? rd_word_q : '0;
  assign recip_prod = 28'(rd_val[WORD_W-2:0]) * 28'(RECIP_100);
  assign opc_x100   = 16'(opc_q) * DEC_BASE;
  assign opa_full   = word_q - opc_x100;
  assign opa_ok     = (opa_q < MEM_LIM);
  assign m_val      = opa_ok ? rd_val : '0;
  assign shr_prod   = 32'(shr_mag_q) * 32'(RECIP_1000);
  assign shr_diff   = shr_mag_q - (WORD_W'(shr_quo_q) * SHR_MOD);
  assign shr_x10    = (WORD_W'(shr_rem_q) << 3) + (WORD_W'(shr_rem_q) << 1);

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    haddr_d   = haddr_q;
    val_d     = val_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    stop_d    = stop_q;
    word_d    = word_q;
    opc_d     = opc_q;
    opa_d     = opa_q;
    next_d    = next_q;
    halt_d    = halt_q;
    st_d      = st_q;
    ov_d      = ov_q;
    oa_d      = oa_q;
    dat_d     = dat_q;
    shr_neg_d = shr_neg_q;
    shr_mag_d = shr_mag_q;
    shr_quo_d = shr_quo_q;
    shr_rem_d = shr_rem_q;
    ovld_d    = ovld_q && !out_o.ready;
    o_st_d    = o_st_q;
    o_ov_d    = o_ov_q;
    o_oa_d    = o_oa_q;
    o_dat_d   = o_dat_q;
    o_acc_d   = o_acc_q;
    o_pc_d    = o_pc_q;
    mem_we    = 1'b0;
    mem_wa    = haddr_q;
    mem_wd    = val_q;
    mem_re    = 1'b0;
    mem_ra    = pc_q;
    alu_req   = '0;
    alu_a     = acc_q;
    alu_b     = m_val;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.op;
          haddr_d = in_i.address;
          val_d   = in_i.value;
          st_d    = ST_OK;
          ov_d    = 1'b0;
          oa_d    = '0;
          dat_d   = '0;
          halt_d  = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RESP;
        case (op_q)
          HOP_WRITE: begin
            mem_we = (haddr_q < MEM_LIM);
          end
          HOP_READ: begin
            if (haddr_q < MEM_LIM) begin
              mem_re  = 1'b1;
              mem_ra  = haddr_q;
              state_d = S_HRD;
            end
          end
          HOP_RESTART: begin
            pc_d   = '0;
            stop_d = 1'b0;
          end
          default: begin
            if (stop_q) begin
              st_d = ST_IGNORED;
            end else if (pc_q >= MEM_LIM) begin
              stop_d = 1'b1;
              st_d   = ST_PAST;
            end else begin
              mem_re  = 1'b1;
              state_d = S_FETCH;
            end
          end
        endcase
      end
      S_HRD: begin
        dat_d   = rd_val;
        state_d = S_RESP;
      end
      S_FETCH: begin
        word_d = rd_val;
        opc_d  = recip_prod[RECIP_SH +: OPC_W];
        next_d = pc_q + ADDR_W'(1);
        // zero and negative words do nothing
        if (rd_val[WORD_W-1] || (rd_val == '0)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        opa_d   = opa_full[ADDR_W-1:0];
        state_d = S_OPR;
      end
      S_OPR: begin
        mem_re  = opa_ok;
        mem_ra  = opa_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FIN;
        mem_wa  = opa_q;
        case (opc_q)
          OPC_READ: begin
            mem_we = opa_ok;
            mem_wd = val_q;
          end
          OPC_WRITE: begin
            ov_d  = 1'b1;
            oa_d  = opa_q;
            dat_d = m_val;
          end
          OPC_LOAD:  acc_d = m_val;
          OPC_STORE: begin
            mem_we = opa_ok;
            mem_wd = acc_q;
          end
          OPC_ADD:   acc_d = acc_q + m_val;
          OPC_SUB:   acc_d = acc_q - m_val;
          OPC_DIV: begin
            if (m_val == '0) begin
              st_d   = ST_DIVZERO;
              halt_d = 1'b1;
            end else begin
              alu_req.start = 1'b1;
              alu_req.div   = 1'b1;
              state_d       = S_ALU;
            end
          end
          OPC_MUL: begin
            alu_req.start = 1'b1;
            state_d       = S_ALU;
          end
          OPC_SHR: begin
            shr_neg_d = m_val[WORD_W-1];
            shr_mag_d = m_val[WORD_W-1] ? (~m_val + WORD_W'(1)) : m_val;
            state_d   = S_SHRQ;
          end
          OPC_BR:     next_d = opa_q;
          OPC_BRNEG:  if (acc_q[WORD_W-1]) next_d = opa_q;
          OPC_BRZERO: if (acc_q == '0) next_d = opa_q;
          OPC_HALT: begin
            st_d   = ST_HALT;
            halt_d = 1'b1;
          end
          default: st_d = ST_UNKNOWN;
        endcase
      end
      S_ALU: begin
        if (alu_done) begin
          case (opc_q)
            OPC_DIV: acc_d = alu_quo;
            default: acc_d = alu_prod;
          endcase
          state_d = S_FIN;
        end
      end
      // remainder by 1000 keeps the sign of the word
      S_SHRQ: begin
        shr_quo_d = shr_prod[RECIP_1000_SH +: SHR_QUO_W];
        state_d   = S_SHRR;
      end
      S_SHRR: begin
        shr_rem_d = shr_diff[SHR_REM_W-1:0];
        state_d   = S_SHRX;
      end
      S_SHRX: begin
        acc_d   = shr_neg_q ? (~shr_x10 + WORD_W'(1)) : shr_x10;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (halt_q) begin
          stop_d = 1'b1;
        end else begin
          if (next_q >= MEM_LIM) begin
            stop_d = 1'b1;
            st_d   = ST_PAST;
          end
          pc_d = next_q;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          o_st_d  = st_q;
          o_ov_d  = ov_q;
          o_oa_d  = oa_q;
          o_dat_d = dat_q;
          o_acc_d = acc_q;
          o_pc_d  = pc_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      acc_q    <= '0;
      stop_q   <= 1'b0;
      ovld_q   <= 1'b0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      ovld_q  <= ovld_d;
      if (mem_we) begin
        vld_q[mem_wa[IDX_W-1:0]] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[mem_ra[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    haddr_q   <= haddr_d;
    val_q     <= val_d;
    word_q    <= word_d;
    opc_q     <= opc_d;
    opa_q     <= opa_d;
    next_q    <= next_d;
    halt_q    <= halt_d;
    st_q      <= st_d;
    ov_q      <= ov_d;
    oa_q      <= oa_d;
    dat_q     <= dat_d;
    shr_neg_q <= shr_neg_d;
    shr_mag_q <= shr_mag_d;
    shr_quo_q <= shr_quo_d;
    shr_rem_q <= shr_rem_d;
    o_st_q    <= o_st_d;
    o_ov_q    <= o_ov_d;
    o_oa_q    <= o_oa_d;
    o_dat_q   <= o_dat_d;
    o_acc_q   <= o_acc_d;
    o_pc_q    <= o_pc_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa[IDX_W-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rd_word_q <= mem_q[mem_ra[IDX_W-1:0]];
    end
  end

  dam_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .quo_o  (alu_quo),
    .prod_o (alu_prod)
  );

  assign out_o.valid       = ovld_q;
  assign out_o.status      = o_st_q;
  assign out_o.out_valid   = o_ov_q;
  assign out_o.out_address = o_oa_q;
  assign out_o.data        = o_dat_q;
  assign out_o.acc_now     = o_acc_q;
  assign out_o.pc_now      = o_pc_q;

endmodule

`default_nettype wire

// File: rtl/core/dam_checker.sv
// dam_checker: port-level assertions for the accumulator machine, bound to the top level
// depends on dam_pkg and decimal_accumulator_machine
`timescale 1ns / 1ps
`default_nettype none

module dam_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [dam_pkg::STAT_W-1:0]        status_i,
  input logic                              out_flag_i,
  input logic [dam_pkg::ADDR_W-1:0]        out_address_i,
  input logic signed [dam_pkg::WORD_W-1:0] data_i,
  input logic [dam_pkg::ADDR_W-1:0]        pc_now_i
);
  import dam_pkg::*;

  // one item in flight: an accepted item closes the input at once
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after an item");

  // a write instruction result never carries a halting status
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_flag_i |-> (status_i == ST_OK) || (status_i == ST_PAST))
    else $error("write output with halting status");

  // halted, divide-by-zero and ignored results never show an output flag or address
  a_quiet_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == ST_HALT) || (status_i == ST_DIVZERO) ||
                    (status_i == ST_IGNORED)) |-> !out_flag_i && (out_address_i == '0))
    else $error("output data on a halting result");

  // a held result stays valid and keeps its status, data and pc
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(data_i)
                                    && $stable(pc_now_i))
    else $error("stalled result changed");

endmodule

bind decimal_accumulator_machine dam_checker u_dam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .out_flag_i    (out_o.out_valid),
  .out_address_i (out_o.out_address),
  .data_i        (out_o.data),
  .pc_now_i      (out_o.pc_now)
);

`default_nettype wire

// File: tb/sv/decimal_accumulator_machine_test.sv
// decimal_accumulator_machine_test: self-checking bench for the decimal accumulator
// machine, with queue-fed driver, monitor and an in-bench machine predictor
// depends on dam_pkg, dam_in_if, dam_out_if and the decimal_accumulator_machine rtl
`timescale 1ns / 1ps

module decimal_accumulator_machine_test;
  import dam_pkg::*;

  localparam int WORDS         = MEM_WORDS_DEF;
  localparam int RANDOM_ITEMS  = 600;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        address;
    logic signed [WORD_W-1:0] value;
  } host_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     out_valid;
    logic [ADDR_W-1:0]        out_address;
    logic signed [WORD_W-1:0] data;
    logic signed [WORD_W-1:0] acc_now;
    logic [ADDR_W-1:0]        pc_now;
  } machine_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dam_in_if  in_ch ();
  dam_out_if out_ch ();

  decimal_accumulator_machine #(
    .MEM_WORDS(WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  host_item_t      item_backlog[$];
  machine_result_t predicted_results[$];

  // machine state as the predictor sees it
  logic [WORD_W-1:0] model_mem [WORDS];
  logic [WORD_W-1:0] model_acc = '0;
  logic [ADDR_W-1:0] model_pc = '0;
  logic              model_stopped = 1'b0;

  int   total_items = 0;
  int   sent_items = 0;
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_taken = 1'b0;

  function automatic logic [WORD_W-1:0] low_word(int x);
    return x[WORD_W-1:0];
  endfunction

  task automatic step_machine(input host_item_t it, output machine_result_t r);
    int   w, m, av, opc, a, nxt;
    logic halt_here;
    r = '0;
    case (it.op)
      HOP_WRITE: if (it.address < WORDS) model_mem[it.address] = it.value;
      HOP_READ: if (it.address < WORDS) r.data = model_mem[it.address];
      HOP_RESTART: begin
        model_pc = '0;
        model_stopped = 1'b0;
      end
      default: begin
        if (model_stopped) begin
          r.status = ST_IGNORED;
        end else if (model_pc >= WORDS) begin
          model_stopped = 1'b1;
          r.status = ST_PAST;
        end else begin
          w = $signed(model_mem[model_pc]);
          nxt = int'(model_pc) + 1;
          halt_here = 1'b0;
          if (w > 0) begin
            opc = w / 100;
            a = w % 100;
            if (a < WORDS) m = $signed(model_mem[a]);
            else m = 0;
            av = $signed(model_acc);
            case (opc[OPC_W-1:0])
              OPC_READ: if (a < WORDS) model_mem[a] = it.value;
              OPC_WRITE: begin
                r.out_valid = 1'b1;
                r.out_address = a[ADDR_W-1:0];
                r.data = low_word(m);
              end
              OPC_LOAD: model_acc = low_word(m);
              OPC_STORE: if (a < WORDS) model_mem[a] = model_acc;
              OPC_ADD: model_acc = low_word(av + m);
              OPC_SUB: model_acc = low_word(av - m);
              OPC_DIV: begin
                if (m == 0) begin
                  r.status = ST_DIVZERO;
                  halt_here = 1'b1;
                end else begin
                  model_acc = low_word(av / m);
                end
              end
              OPC_MUL: model_acc = low_word(av * m);
              OPC_BR: nxt = a;
              OPC_BRNEG: if (av < 0) nxt = a;
              OPC_BRZERO: if (av == 0) nxt = a;
              OPC_HALT: begin
                r.status = ST_HALT;
                halt_here = 1'b1;
              end
              OPC_SHR: model_acc = low_word((m % 1000) * 10);
              default: r.status = ST_UNKNOWN;
            endcase
          end
          if (halt_here) begin
            model_stopped = 1'b1;
          end else begin
            if (nxt >= WORDS) begin
              model_stopped = 1'b1;
              r.status = ST_PAST;
            end
            model_pc = nxt[ADDR_W-1:0];
          end
        end
      end
    endcase
    r.acc_now = model_acc;
    r.pc_now = model_pc;
  endtask

  task automatic add_item(logic [OP_W-1:0] op, int addr, int val);
    host_item_t it;
    it.op = op;
    it.address = addr[ADDR_W-1:0];
    it.value = val[WORD_W-1:0];
    item_backlog.push_back(it);
  endtask

  function automatic int instr_word(logic [OPC_W-1:0] opc, int a);
    return int'(opc) * 100 + a;
  endfunction

  function automatic int rand_word();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 0;
      4: return $urandom_range(0, 40) - 20;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic logic [OPC_W-1:0] pick_opcode();
    case ($urandom_range(0, 12))
      0: return OPC_READ;
      1: return OPC_WRITE;
      2: return OPC_LOAD;
      3: return OPC_STORE;
      4: return OPC_ADD;
      5: return OPC_SUB;
      6: return OPC_DIV;
      7: return OPC_MUL;
      8: return OPC_BR;
      9: return OPC_BRNEG;
      10: return OPC_BRZERO;
      11: return OPC_HALT;
      default: return OPC_SHR;
    endcase
  endfunction

  function automatic int rand_instr(int prog_len);
    int pick, a;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: a = $urandom_range(0, prog_len);
      1: a = $urandom_range(40, 59);
      default: a = $urandom_range(90, 99);
    endcase
    if (pick < 6) return $urandom_range(1, 99);
    if (pick < 10) return -int'($urandom_range(0, 32768));
    if (pick < 15) return $urandom_range(1, 32767);
    return instr_word(pick_opcode(), a);
  endfunction

  // directed part, random programs, then drain and verdict
  initial begin
    int n, k;
    add_item(HOP_READ, 127, 0);
    add_item(HOP_WRITE, 127, 32767);
    add_item(HOP_WRITE, 50, -32768);
    add_item(HOP_WRITE, 51, -1);
    add_item(HOP_WRITE, 0, instr_word(OPC_LOAD, 50));
    add_item(HOP_WRITE, 1, instr_word(OPC_DIV, 51));
    add_item(HOP_WRITE, 2, instr_word(OPC_SHR, 50));
    add_item(HOP_WRITE, 3, instr_word(OPC_BRNEG, 99));
    add_item(HOP_WRITE, 99, instr_word(OPC_WRITE, 50));
    for (int i = 0; i < 6; i++) add_item(HOP_EXEC, 0, 16'h5a5a);
    add_item(HOP_READ, 50, 0);
    add_item(HOP_RESTART, 0, 0);
    add_item(HOP_WRITE, 0, 32767);
    add_item(HOP_WRITE, 1, instr_word(OPC_READ, 52));
    add_item(HOP_WRITE, 2, instr_word(OPC_HALT, 0));
    add_item(HOP_EXEC, 127, 0);
    add_item(HOP_EXEC, 0, 12345);
    add_item(HOP_EXEC, 0, -1);
    add_item(HOP_READ, 52, 0);
    add_item(HOP_RESTART, 0, 0);
    add_item(HOP_WRITE, 0, 0);
    add_item(HOP_EXEC, 0, 0);

    k = item_backlog.size() + RANDOM_ITEMS;
    while (item_backlog.size() < k) begin
      if ($urandom_range(0, 99) < 15) begin
        add_item($urandom_range(0, 3), $urandom_range(0, 127), int'($urandom));
      end else begin
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++) add_item(HOP_WRITE, i, rand_instr(n));
        for (int i = $urandom_range(0, 3); i > 0; i--)
          add_item(HOP_WRITE, $urandom_range(90, 99), rand_instr(n));
        for (int i = $urandom_range(1, 4); i > 0; i--)
          add_item(HOP_WRITE, $urandom_range(40, 59), rand_word());
        add_item(HOP_RESTART, $urandom_range(0, 127), int'($urandom));
        for (int i = $urandom_range(n, n + 8); i > 0; i--) begin
          if ($urandom_range(0, 9) == 0) add_item(HOP_READ, $urandom_range(0, 99), 0);
          else add_item(HOP_EXEC, $urandom_range(0, 127), rand_word());
        end
      end
    end
    total_items = item_backlog.size();

    wait (rst_ni === 1'b1);
    while (item_backlog.size() != 0 || in_ch.valid === 1'b1 || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = HOP_WRITE;
    in_ch.address = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < WORDS; i++) model_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // driver
  always @(negedge clk_i) begin
    host_item_t it;
    if (rst_ni) begin
      if (sent_items < total_items / 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 53;
      end else if (sent_items < 2 * total_items / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!in_ch.valid || in_taken) begin
        if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = item_backlog.pop_front();
          sent_items++;
          in_ch.valid <= 1'b1;
          in_ch.op <= it.op;
          in_ch.address <= it.address;
          in_ch.value <= it.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    host_item_t      it;
    machine_result_t want, got;
    if (rst_ni) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        it.op = in_ch.op;
        it.address = in_ch.address;
        it.value = in_ch.value;
        step_machine(it, want);
        predicted_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.out_valid = out_ch.out_valid;
        got.out_address = out_ch.out_address;
        got.data = out_ch.data;
        got.acc_now = out_ch.acc_now;
        got.pc_now = out_ch.pc_now;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing awaited: status %0d data %0d", $realtime,
                     got.status, got.data);
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status || got.out_valid !== want.out_valid ||
              got.out_address !== want.out_address || got.data !== want.data ||
              got.acc_now !== want.acc_now || got.pc_now !== want.pc_now) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: status/ov/oaddr/data/acc/pc expected %0d %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d %0d",
                       $realtime, want.status, want.out_valid, want.out_address, want.data,
                       want.acc_now, want.pc_now, got.status, got.out_valid,
                       got.out_address, got.data, got.acc_now, got.pc_now);
          end
        end
      end
    end
  end

endmodule
